// ===== src/okvt_pkg.sv =====
// Package for the ordered key/value table: sizes, field layout, action codes and
// the sequencer state type. Depends on nothing; imported by ordered_key_value_table.
`timescale 1ns / 1ps
`default_nettype none

package okvt_pkg;

  localparam int DEPTH      = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int ACT_W      = 3;
  localparam int POS_W      = 4;
  localparam int ENTRY_W    = 5;

  // Slave-side tdata: req_key, new_value, position, zero fill.
  localparam int S_KEY_LSB  = 0;
  localparam int S_VAL_LSB  = S_KEY_LSB + KEY_BITS;
  localparam int S_POS_LSB  = S_VAL_LSB + VALUE_BITS;
  localparam int S_USED_W   = S_POS_LSB + POS_W;
  localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

  // Master-side tdata: ok, full_res, found_key, found_value, entry_count, zero fill.
  localparam int M_OK_BIT   = 0;
  localparam int M_FULL_BIT = 1;
  localparam int M_KEY_LSB  = 2;
  localparam int M_VAL_LSB  = M_KEY_LSB + KEY_BITS;
  localparam int M_CNT_LSB  = M_VAL_LSB + VALUE_BITS;
  localparam int M_USED_W   = M_CNT_LSB + ENTRY_W;
  localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_UPDATE  = 3'd1,
    ACT_UPSERT  = 3'd2,
    ACT_ERASE   = 3'd3,
    ACT_LOOKUP  = 3'd4,
    ACT_READPOS = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_READ,
    S_RESULT
  } state_t;

endpackage

`default_nettype wire

// ===== src/ordered_key_value_table.sv =====
// Ordered key/value table: sequencer, entry storage and result register.
// Depends on okvt_pkg for sizes, field layout, action codes and state type.
`timescale 1ns / 1ps
`default_nettype none

// The block holds up to DEPTH unique key/value pairs in the order in which they
// were inserted. Each request transfer on the slave side carries the action in
// s_tuser and gives exactly one result transfer on the master side. Keys and
// values live in two single-port-write memories with a registered read port;
// one shared key comparator walks the entries under a small sequencer, one
// entry per cycle. Insert, update, insert-or-update, erase and lookup start
// with a key search. Erase follows the search with a compaction that copies
// each later entry down by one position, one per cycle. Read-at-position reads
// its entry through the registered read port; an unused action code or a
// position beyond the entry count goes straight to the result. A stalled
// master side holds the sequencer in its result state.
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register, so the next request may be taken before the
// previous result has been collected. Storage needs no clearing after reset:
// only entries below the entry count are ever used.
module ordered_key_value_table (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // tdata, from bit 0: req_key[31:0], new_value[31:0], position[3:0], zero fill
  input  wire logic [okvt_pkg::S_TDATA_W-1:0] s_tdata,
  // tuser: action[2:0]
  input  wire logic [okvt_pkg::ACT_W-1:0]   s_tuser,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // tdata, from bit 0: ok, full_res, found_key[31:0], found_value[31:0],
  // entry_count[4:0], zero fill
  output logic [okvt_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                              m_tvalid,
  input  wire logic                         m_tready
);

  import okvt_pkg::*;

  // Entry storage.
  logic [KEY_BITS-1:0]   key_mem [DEPTH];
  logic [VALUE_BITS-1:0] val_mem [DEPTH];
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  // Sequencer state.
  state_t                state, state_next;
  action_t               act;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;
  logic [CNT_W-1:0]      count, count_next;
  logic [CNT_W-1:0]      rd_idx, rd_idx_next;
  logic [CNT_W-1:0]      wr_idx, wr_idx_next;
  logic [CNT_W-1:0]      q_idx;
  logic                  q_live, q_live_next;

  // Result being built.
  logic                  res_ok, res_ok_next;
  logic                  res_full, res_full_next;
  logic [KEY_BITS-1:0]   res_key, res_key_next;
  logic [VALUE_BITS-1:0] res_val, res_val_next;

  // Memory write port.
  logic                  wr_en, wr_key_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [VALUE_BITS-1:0] wr_val;

  // Decisions shared by the next-state and output logic.
  logic                  s_accept, out_free, out_load;
  logic [POS_W-1:0]      in_pos;
  logic                  pos_ok;
  logic                  q_in, q_hit, q_miss, shift_done, table_full;

  assign s_accept   = s_tvalid && s_tready;
  assign s_tready   = (state == S_IDLE);
  assign out_free   = !m_tvalid || m_tready;
  assign out_load   = (state == S_RESULT) && out_free;
  assign in_pos     = s_tdata[S_POS_LSB +: POS_W];
  assign pos_ok     = 32'(in_pos) < 32'(count);
  assign q_in       = q_idx < count;
  assign q_hit      = q_live && q_in && (key_q == req_key);
  assign q_miss     = q_live && !q_in;
  assign shift_done = (wr_idx + CNT_W'(1)) >= count;
  assign table_full = count == CNT_W'(DEPTH);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          case (action_t'(s_tuser))
            ACT_INSERT, ACT_UPDATE, ACT_UPSERT, ACT_ERASE, ACT_LOOKUP: begin
              state_next = S_SEARCH;
            end
            ACT_READPOS: begin
              state_next = pos_ok ? S_READ : S_RESULT;
            end
            default: begin
              state_next = S_RESULT;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (q_hit && act == ACT_ERASE) begin
          state_next = S_SHIFT;
        end else if (q_hit || q_miss) begin
          state_next = S_RESULT;
        end
      end
      S_SHIFT: begin
        if (shift_done) begin
          state_next = S_RESULT;
        end
      end
      S_READ: begin
        if (q_live) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Datapath control for each state.
  always_comb begin
    count_next    = count;
    rd_idx_next   = rd_idx;
    wr_idx_next   = wr_idx;
    q_live_next   = q_live;
    res_ok_next   = res_ok;
    res_full_next = res_full;
    res_key_next  = res_key;
    res_val_next  = res_val;
    wr_en         = 1'b0;
    wr_key_en     = 1'b0;
    wr_addr       = q_idx[IDX_W-1:0];
    wr_key        = req_key;
    wr_val        = req_value;

    case (state)
      S_IDLE: begin
        if (s_accept) begin
          res_ok_next   = 1'b0;
          res_full_next = 1'b0;
          res_key_next  = '0;
          res_val_next  = '0;
          q_live_next   = 1'b0;
          rd_idx_next   = (action_t'(s_tuser) == ACT_READPOS) ? CNT_W'(in_pos) : '0;
        end
      end
      S_SEARCH: begin
        q_live_next = 1'b1;
        if (rd_idx < count) begin
          rd_idx_next = rd_idx + CNT_W'(1);
        end
        if (q_hit) begin
          case (act)
            ACT_UPDATE, ACT_UPSERT: begin
              wr_en       = 1'b1;
              res_ok_next = 1'b1;
            end
            ACT_ERASE: begin
              rd_idx_next = q_idx + CNT_W'(1);
              wr_idx_next = q_idx;
              q_live_next = 1'b0;
            end
            ACT_LOOKUP: begin
              res_ok_next  = 1'b1;
              res_key_next = key_q;
              res_val_next = val_q;
            end
            default: begin
            end
          endcase
        end else if (q_miss) begin
          if (act == ACT_INSERT || act == ACT_UPSERT) begin
            if (table_full) begin
              res_full_next = 1'b1;
            end else begin
              wr_en       = 1'b1;
              wr_key_en   = 1'b1;
              wr_addr     = count[IDX_W-1:0];
              count_next  = count + CNT_W'(1);
              res_ok_next = 1'b1;
            end
          end
        end
      end
      S_SHIFT: begin
        if (shift_done) begin
          count_next  = count - CNT_W'(1);
          res_ok_next = 1'b1;
        end else begin
          q_live_next = 1'b1;
          if (rd_idx < count) begin
            rd_idx_next = rd_idx + CNT_W'(1);
          end
          if (q_live) begin
            wr_en       = 1'b1;
            wr_key_en   = 1'b1;
            wr_addr     = wr_idx[IDX_W-1:0];
            wr_key      = key_q;
            wr_val      = val_q;
            wr_idx_next = wr_idx + CNT_W'(1);
          end
        end
      end
      S_READ: begin
        q_live_next = 1'b1;
        if (q_live) begin
          res_ok_next  = 1'b1;
          res_key_next = key_q;
          res_val_next = val_q;
        end
      end
      S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  // Storage: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_key_en) begin
        key_mem[wr_addr] <= wr_key;
      end
      val_mem[wr_addr] <= wr_val;
    end
    key_q <= key_mem[rd_idx[IDX_W-1:0]];
    val_q <= val_mem[rd_idx[IDX_W-1:0]];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      q_live   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      q_live <= q_live_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_idx   <= rd_idx_next;
    wr_idx   <= wr_idx_next;
    q_idx    <= rd_idx;
    res_ok   <= res_ok_next;
    res_full <= res_full_next;
    res_key  <= res_key_next;
    res_val  <= res_val_next;
    if (s_accept) begin
      act       <= action_t'(s_tuser);
      req_key   <= s_tdata[S_KEY_LSB +: KEY_BITS];
      req_value <= s_tdata[S_VAL_LSB +: VALUE_BITS];
    end
    if (out_load) begin
      m_tdata <= M_TDATA_W'({ENTRY_W'(count), res_val, res_key, res_full, res_ok});
    end
  end

  // The entry count never exceeds the table size.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond table size");

  // Without a request the table contents count stays put.
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !s_accept) |=> count == $past(count))
    else $error("entry count changed while idle");

  // A result carries the entry count left by its own request.
  a_result_count: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tdata[M_CNT_LSB +: ENTRY_W] == ENTRY_W'($past(count)))
    else $error("result entry count mismatch");

  // A table-full result is only given when every entry is in use.
  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_full) |-> table_full)
    else $error("full flag with free entries");

  // Compaction only runs on a non-empty table.
  a_shift_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> count != '0)
    else $error("erase compaction on an empty table");

endmodule

`default_nettype wire

// ===== bench/ordered_key_value_table_tb.sv =====
// Self-checking bench for the ordered key/value table: directed table plus episodes of
// random requests, each result checked against its written expectation or a shadow table.
// Depends on okvt_pkg and ordered_key_value_table from the source folder.
`timescale 1ns / 1ps

module ordered_key_value_table_tb;
  import okvt_pkg::*;

  // Action codes with no operation behind them; only this bench uses them.
  localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

  localparam int DIR_ROWS      = 21;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int IDLE_LIMIT    = 4000;

  typedef struct packed {
    logic                  ok;
    logic                  full_res;
    logic [KEY_BITS-1:0]   found_key;
    logic [VALUE_BITS-1:0] found_value;
    logic [ENTRY_W-1:0]    entry_count;
  } kv_result_t;

  // One directed request; where typed is set, res is the expected result as written.
  typedef struct packed {
    logic [ACT_W-1:0]      action;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [POS_W-1:0]      pos;
    logic                  typed;
    kv_result_t            res;
  } stim_row_t;

  localparam kv_result_t NOTHING_FOUND = '0;

  logic                 clk;
  logic                 rst;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [ACT_W-1:0]     s_tuser;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tvalid;
  logic                 m_tready;

  ordered_key_value_table uut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  // Shadow copy of the table, advanced once per accepted request.
  logic [KEY_BITS-1:0]   tbl_keys   [DEPTH];
  logic [VALUE_BITS-1:0] tbl_values [DEPTH];
  int                    tbl_count;

  kv_result_t pending_results [$];
  int         mismatches;
  int         requests_sent;
  int         burst_left;
  bit         hold_request;
  stim_row_t  directed [DIR_ROWS];

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int table_find(input logic [KEY_BITS-1:0] key);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_keys[i] == key) return i;
    end
    return -1;
  endfunction

  // Applies one request to the shadow table and gives the result the block should return.
  function automatic kv_result_t table_apply(input logic [ACT_W-1:0] act,
                                             input logic [KEY_BITS-1:0] key,
                                             input logic [VALUE_BITS-1:0] val,
                                             input logic [POS_W-1:0] pos);
    kv_result_t r;
    int hit;
    r = NOTHING_FOUND;
    hit = table_find(key);
    case (act)
      ACT_INSERT, ACT_UPSERT: begin
        if (hit >= 0) begin
          if (act == ACT_UPSERT) begin
            tbl_values[hit] = val;
            r.ok = 1'b1;
          end
        end else if (tbl_count >= DEPTH) begin
          r.full_res = 1'b1;
        end else begin
          tbl_keys[tbl_count]   = key;
          tbl_values[tbl_count] = val;
          tbl_count++;
          r.ok = 1'b1;
        end
      end
      ACT_UPDATE: begin
        if (hit >= 0) begin
          tbl_values[hit] = val;
          r.ok = 1'b1;
        end
      end
      ACT_ERASE: begin
        if (hit >= 0) begin
          for (int i = hit; i + 1 < tbl_count; i++) begin
            tbl_keys[i]   = tbl_keys[i + 1];
            tbl_values[i] = tbl_values[i + 1];
          end
          tbl_count--;
          r.ok = 1'b1;
        end
      end
      ACT_LOOKUP: begin
        if (hit >= 0) begin
          r.found_key   = tbl_keys[hit];
          r.found_value = tbl_values[hit];
          r.ok          = 1'b1;
        end
      end
      ACT_READPOS: begin
        if (int'(pos) < tbl_count) begin
          r.found_key   = tbl_keys[pos];
          r.found_value = tbl_values[pos];
          r.ok          = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = tbl_count[ENTRY_W-1:0];
    return r;
  endfunction

  // Mostly plain random keys, with the all-zero, all-one and one-hot patterns mixed in.
  function automatic logic [KEY_BITS-1:0] random_key();
    logic [KEY_BITS-1:0] k;
    case ($urandom_range(0, 15))
      0: k = '0;
      1: k = '1;
      2: begin
        k = '0;
        k[$urandom_range(0, KEY_BITS - 1)] = 1'b1;
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  function automatic logic [KEY_BITS-1:0] stored_key();
    return tbl_keys[$urandom_range(0, tbl_count - 1)];
  endfunction

  function automatic logic [POS_W-1:0] random_position();
    if (tbl_count > 0 && $urandom_range(0, 3) != 0)
      return POS_W'($urandom_range(0, tbl_count - 1));
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  // Called at a falling edge. Offers one request, possibly after a gap that ends a burst,
  // and returns at the falling edge after the transfer with its expectation queued.
  task automatic send_request(input logic [ACT_W-1:0] act,
                              input logic [KEY_BITS-1:0] key,
                              input logic [VALUE_BITS-1:0] val,
                              input logic [POS_W-1:0] pos,
                              input bit typed = 1'b0,
                              input kv_result_t typed_res = '0);
    logic [S_TDATA_W-1:0] word;
    kv_result_t r;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
    end
    word = '0;
    word[S_KEY_LSB +: KEY_BITS]   = key;
    word[S_VAL_LSB +: VALUE_BITS] = val;
    word[S_POS_LSB +: POS_W]      = pos;
    s_tdata  = word;
    s_tuser  = act;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    r = table_apply(act, key, val, pos);
    pending_results.push_back(typed ? typed_res : r);
    requests_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Receiver: picks a new stall mode at random once the current one runs out, and on request
  // holds off entirely for a long stretch so that the block backs up into its input.
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    int phase;
    logic [7:0] stall_pattern;
    m_tready = 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    phase = 0;
    stall_pattern = 8'b1011_0010;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (mode)
          0: m_tready = 1'b1;
          1: m_tready = ($urandom_range(0, 3) != 0);
          2: m_tready = ($urandom_range(0, 3) == 0);
          default: begin
            m_tready = stall_pattern[phase];
            phase = (phase + 1) % 8;
          end
        endcase
      end
    end
  end

  // Every result transfer is compared with the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    kv_result_t got;
    kv_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.ok          = m_tdata[M_OK_BIT];
      got.full_res    = m_tdata[M_FULL_BIT];
      got.found_key   = m_tdata[M_KEY_LSB +: KEY_BITS];
      got.found_value = m_tdata[M_VAL_LSB +: VALUE_BITS];
      got.entry_count = m_tdata[M_CNT_LSB +: ENTRY_W];
      if (pending_results.size() == 0) begin
        $error("result transfer with no request outstanding: tdata %h", m_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, got.ok);
          mismatches++;
        end
        if (got.full_res !== want.full_res) begin
          $error("full_res: expected %0d, got %0d", want.full_res, got.full_res);
          mismatches++;
        end
        if (got.found_key !== want.found_key) begin
          $error("found_key: expected %h, got %h", want.found_key, got.found_key);
          mismatches++;
        end
        if (got.found_value !== want.found_value) begin
          $error("found_value: expected %h, got %h", want.found_value, got.found_value);
          mismatches++;
        end
        if (got.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no transfer on either side means a hang.
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int kind;
    int n;
    int pick;
    int holds_issued;
    logic [KEY_BITS-1:0] k;

    rst = 1'b1;
    s_tdata = '0;
    s_tuser = ACT_INSERT;
    s_tvalid = 1'b0;
    mismatches = 0;
    requests_sent = 0;
    burst_left = 0;
    hold_request = 1'b0;
    holds_issued = 0;
    tbl_count = 0;

    // Directed rows: empty-table misses, spare codes, extremes, duplicate insert, a hit,
    // then value changes, an erase that closes the gap and out-of-range positions.
    directed = '{
      '{ACT_LOOKUP,  32'h0000_0000, 32'h0000_0000, 4'd0,  1'b1, NOTHING_FOUND},
      '{ACT_READPOS, 32'h0000_0000, 32'h0000_0000, 4'd0,  1'b1, NOTHING_FOUND},
      '{ACT_READPOS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1, NOTHING_FOUND},
      '{ACT_UPDATE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0,  1'b1, NOTHING_FOUND},
      '{ACT_ERASE,   32'hFFFF_FFFF, 32'h0000_0000, 4'd0,  1'b1, NOTHING_FOUND},
      '{ACT_SPARE6,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1, NOTHING_FOUND},
      '{ACT_SPARE7,  32'h0000_0000, 32'h0000_0000, 4'd0,  1'b1, NOTHING_FOUND},
      '{ACT_INSERT,  32'h0000_0000, 32'h0000_0000, 4'd0,  1'b1,
        '{1'b1, 1'b0, 32'h0, 32'h0, 5'd1}},
      '{ACT_INSERT,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0,  1'b1,
        '{1'b1, 1'b0, 32'h0, 32'h0, 5'd2}},
      '{ACT_INSERT,  32'h0000_0000, 32'h1234_5678, 4'd0,  1'b1,
        '{1'b0, 1'b0, 32'h0, 32'h0, 5'd2}},
      '{ACT_LOOKUP,  32'hFFFF_FFFF, 32'h0000_0000, 4'd0,  1'b1,
        '{1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd2}},
      '{ACT_UPDATE,  32'h0000_0000, 32'hA5A5_A5A5, 4'd0,  1'b0, NOTHING_FOUND},
      '{ACT_UPSERT,  32'h0000_0000, 32'h5A5A_5A5A, 4'd0,  1'b0, NOTHING_FOUND},
      '{ACT_UPSERT,  32'h8000_0001, 32'h0000_0001, 4'd0,  1'b0, NOTHING_FOUND},
      '{ACT_READPOS, 32'h0000_0000, 32'h0000_0000, 4'd1,  1'b0, NOTHING_FOUND},
      '{ACT_READPOS, 32'h0000_0000, 32'h0000_0000, 4'd2,  1'b0, NOTHING_FOUND},
      '{ACT_READPOS, 32'h0000_0000, 32'h0000_0000, 4'd3,  1'b0, NOTHING_FOUND},
      '{ACT_ERASE,   32'h0000_0000, 32'h0000_0000, 4'd0,  1'b0, NOTHING_FOUND},
      '{ACT_READPOS, 32'h0000_0000, 32'h0000_0000, 4'd0,  1'b0, NOTHING_FOUND},
      '{ACT_LOOKUP,  32'h0000_0000, 32'h0000_0000, 4'd0,  1'b0, NOTHING_FOUND},
      '{ACT_SPARE7,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b0, NOTHING_FOUND}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_request(directed[i].action, directed[i].key, directed[i].value, directed[i].pos,
                   directed[i].typed, directed[i].res);
    end
    wait_for_results();

    // Random part in episodes. The first one always fills the table so that the
    // full-table cases are reached early; later ones are picked at random.
    kind = 0;
    while (requests_sent < DIR_ROWS + RANDOM_ITEMS) begin
      case (kind)
        0, 1: begin
          while (tbl_count < DEPTH) begin
            send_request(ACT_INSERT, random_key(), $urandom, random_position());
          end
          // Probes on a full table: new key refused as full, existing key refused
          // without the full flag, insert-or-update both ways, last position.
          send_request(ACT_INSERT, $urandom, $urandom, random_position());
          send_request(ACT_INSERT, stored_key(), $urandom, random_position());
          send_request(ACT_UPSERT, $urandom, $urandom, random_position());
          send_request(ACT_UPSERT, stored_key(), $urandom, random_position());
          send_request(ACT_UPDATE, stored_key(), $urandom, random_position());
          send_request(ACT_READPOS, random_key(), $urandom, POS_W'(DEPTH - 1));
          send_request(ACT_LOOKUP, stored_key(), $urandom, random_position());
        end
        2, 3, 4, 5, 6: begin
          n = $urandom_range(8, 40);
          repeat (n) begin
            k = (tbl_count > 0 && $urandom_range(0, 3) != 0) ? stored_key() : random_key();
            pick = $urandom_range(0, 99);
            if (pick < 25)      send_request(ACT_INSERT,  k, $urandom, random_position());
            else if (pick < 35) send_request(ACT_UPDATE,  k, $urandom, random_position());
            else if (pick < 50) send_request(ACT_UPSERT,  k, $urandom, random_position());
            else if (pick < 65) send_request(ACT_ERASE,   k, $urandom, random_position());
            else if (pick < 82) send_request(ACT_LOOKUP,  k, $urandom, random_position());
            else                send_request(ACT_READPOS, k, $urandom, random_position());
          end
        end
        7, 8: begin
          // Drain in random order; the compaction is checked by the reads that follow.
          while (tbl_count > 0) begin
            k = stored_key();
            send_request(ACT_ERASE, k, $urandom, random_position());
            if ($urandom_range(0, 2) == 0)
              send_request(ACT_LOOKUP, k, $urandom, random_position());
            else
              send_request(ACT_READPOS, random_key(), $urandom, random_position());
          end
        end
        default: begin
          n = $urandom_range(2, 6);
          repeat (n) begin
            send_request(ACT_W'($urandom_range(0, 7)), $urandom, $urandom,
                         POS_W'($urandom_range(0, 15)));
          end
        end
      endcase

      // Two long receiver hold-offs while requests keep coming, so that the output
      // register fills and the input stalls.
      if (holds_issued < 2 && requests_sent >= 300 * (holds_issued + 1)) begin
        hold_request = 1'b1;
        holds_issued++;
      end else if ($urandom_range(0, 7) == 0) begin
        wait_for_results();
      end
      kind = $urandom_range(0, 9);
    end

    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
